[hw/rtl/ecl2eq_pkg.sv]
// Shared types, constants and elaboration-time helpers for the ecliptic to
// equatorial rotation core. No dependencies; imported by every RTL file.
package ecl2eq_pkg;

   localparam int ANGLE_BITS_DEF  = 32;
   localparam int CORDIC_ITER_DEF = 30;

   // Vector components: signed Q30 with headroom for CORDIC growth
   localparam int VEC_W    = 34;
   localparam int VEC_FRAC = 30;
   localparam int OBLQ_W   = 31;

   typedef logic signed [VEC_W-1:0] vec_type;

   // CORDIC gain compensation, Q30 (about 0.607253)
   localparam vec_type GAIN_Q30 = 34'sd652032874;
   localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

   typedef struct packed {
      logic [31:0]        ecliptic_longitude;
      logic signed [31:0] ecliptic_latitude;
   } req_type;

   typedef struct packed {
      logic [31:0]        right_ascension;
      logic signed [31:0] declination;
   } rsp_type;

   // atan(2^-idx) in turns, rounded half up to abits; used at elaboration only
   function automatic logic [63:0] atan_entry(input int idx, input int abits);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [63:0]  turns;
      logic [127:0] prod;
      int           k;
      int           e;
      r = '0;
      if (idx == 0) begin
         return 64'd1 << (abits - 3);
      end
      // arctangent series in Q62 radians, truncated terms
      for (k = 0; (2 * k + 1) * idx <= 62; k++) begin
         e = (2 * k + 1) * idx;
         t = (64'd1 << (62 - e)) / 64'(2 * k + 1);
         if (k[0]) begin
            r = r - t;
         end else begin
            r = r + t;
         end
      end
      prod  = {64'd0, r} * {64'd0, INV_TWO_PI_Q64};
      turns = prod[127:64];
      return (turns + (64'd1 << (61 - abits))) >> (62 - abits);
   endfunction

   // Q30 product, floored
   function automatic vec_type mulq(input vec_type a, input vec_type b);
      logic signed [2*VEC_W-1:0] p;
      p = a * b;
      return VEC_W'(p >>> VEC_FRAC);
   endfunction

endpackage

[hw/rtl/ecl2eq_cordic.sv]
// Fully pipelined CORDIC, one register stage per iteration, rotation or
// vectoring mode, with a side word carried alongside. Uses ecl2eq_pkg.
module ecl2eq_cordic #(
   parameter int ANGLE_BITS = ecl2eq_pkg::ANGLE_BITS_DEF,
   parameter int ITERATIONS = ecl2eq_pkg::CORDIC_ITER_DEF,
   parameter bit VECTORING  = 1'b0,
   parameter int SIDE_W     = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  ecl2eq_pkg::vec_type         in_x,
   input  ecl2eq_pkg::vec_type         in_y,
   input  logic signed [ANGLE_BITS+1:0] in_z,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output ecl2eq_pkg::vec_type         out_x,
   output ecl2eq_pkg::vec_type         out_y,
   output logic signed [ANGLE_BITS+1:0] out_z,
   output logic [SIDE_W-1:0]           out_side
);
   import ecl2eq_pkg::*;

   localparam int ZW = ANGLE_BITS + 2;

   logic [ITERATIONS-1:0]  valid_ff;
   vec_type                x_ff    [ITERATIONS];
   vec_type                y_ff    [ITERATIONS];
   logic signed [ZW-1:0]   z_ff    [ITERATIONS];
   logic [SIDE_W-1:0]      side_ff [ITERATIONS];

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ATAN = ZW'(atan_entry(i, ANGLE_BITS));

      logic                 v_prev;
      vec_type              x_prev;
      vec_type              y_prev;
      logic signed [ZW-1:0] z_prev;
      logic [SIDE_W-1:0]    side_prev;
      vec_type              x_in;
      vec_type              y_in;
      logic signed [ZW-1:0] z_in;
      logic                 up;

      if (i == 0) begin : g_head
         assign v_prev    = in_valid;
         assign x_prev    = in_x;
         assign y_prev    = in_y;
         assign z_prev    = in_z;
         assign side_prev = in_side;
      end else begin : g_tail
         assign v_prev    = valid_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      // micro-rotation; vectoring drives y to zero, rotation drives z to zero
      always_comb begin
         if (VECTORING) begin
            up = (y_prev > 0);
         end else begin
            up = (z_prev >= 0);
         end
         if (up ^ VECTORING) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - ATAN;
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ITERATIONS-1];
   assign out_x     = x_ff[ITERATIONS-1];
   assign out_y     = y_ff[ITERATIONS-1];
   assign out_z     = z_ff[ITERATIONS-1];
   assign out_side  = side_ff[ITERATIONS-1];

endmodule

[hw/rtl/ecliptic_to_equatorial_core.sv]
// Ecliptic to equatorial rotation core: top level. Uses ecl2eq_pkg and
// ecl2eq_cordic (three rotation lanes, two vectoring chains).
//
// Takes one (longitude, latitude) pair per clock and returns right ascension
// in [0, 1 turn) and declination clamped to +-1/4 turn, all 32-bit binary
// angles. From transfer to result valid an item passes through three CORDIC
// chains in series: sine/cosine, then the right-ascension arctangent, then
// the declination arctangent, each one register per iteration. Throughput
// is one transfer per cycle; the whole pipeline freezes only while a finished
// result is held by rsp_stall. The obliquity register is sampled per item, so
// write it only while the pipeline is empty.
module ecliptic_to_equatorial_core #(
   parameter int ANGLE_BITS        = ecl2eq_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_ITERATIONS = ecl2eq_pkg::CORDIC_ITER_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [ecl2eq_pkg::OBLQ_W-1:0]     csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ecl2eq_pkg::req_type               req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ecl2eq_pkg::rsp_type               rsp_payload
);
   import ecl2eq_pkg::*;

   localparam int AW = ANGLE_BITS;
   localparam int ZW = ANGLE_BITS + 2;
   localparam logic signed [ZW-1:0] QUARTER_Z = ZW'(longint'(1) << (AW - 2));
   localparam logic signed [ZW-1:0] HALF_Z    = ZW'(longint'(1) << (AW - 1));

   typedef logic signed [ZW-1:0] zang_type;

   // 32-bit binary angle to internal width
   function automatic logic [AW-1:0] angle_in(input logic [31:0] u);
      logic [AW+31:0] wide;
      wide = {u, {AW{1'b0}}};
      return wide[AW+31:32];
   endfunction

   // internal angle back to 32 bits, rounding half up when narrowing
   function automatic logic [31:0] angle_out(input logic [AW-1:0] a);
      logic [AW+32:0] sum;
      sum = {1'b0, a, 32'd0} + ((AW + 33)'(1) << (AW - 1));
      return sum[AW+31:AW];
   endfunction

   typedef struct packed {
      zang_type z;
      logic     neg;
   } fold_type;

   // fold an angle into +-1/4 turn, remembering the half-turn flip
   function automatic fold_type fold(input logic [AW-1:0] a);
      fold_type f;
      f.z   = ZW'(signed'(a));
      f.neg = 1'b0;
      if (f.z > QUARTER_Z) begin
         f.z   = f.z - HALF_Z;
         f.neg = 1'b1;
      end else if (f.z < -QUARTER_Z) begin
         f.z   = f.z + HALF_Z;
         f.neg = 1'b1;
      end
      return f;
   endfunction

   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // obliquity register
   logic [OBLQ_W-1:0] obliquity_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         obliquity_ff <= '0;
      end else if (csr_write_enable) begin
         obliquity_ff <= csr_write_data;
      end
   end

   // stage 0: input transfer, angle folding
   fold_type fl_in, fb_in, fe_in;
   fold_type fl_ff, fb_ff, fe_ff;
   logic     v0_ff;
   assign fl_in = fold(angle_in(req_payload.ecliptic_longitude));
   assign fb_in = fold(angle_in(req_payload.ecliptic_latitude));
   assign fe_in = fold(angle_in({1'b0, obliquity_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         fl_ff <= fl_in;
         fb_ff <= fb_in;
         fe_ff <= fe_in;
      end
   end

   // sine/cosine lanes
   logic     rl_v, rb_v, re_v;
   vec_type  rl_x, rl_y, rb_x, rb_y, re_x, re_y;
   zang_type rl_z, rb_z, re_z;
   logic     rl_n, rb_n, re_n;

   ecl2eq_cordic #(.ANGLE_BITS(AW), .ITERATIONS(CORDIC_ITERATIONS),
                   .VECTORING(1'b0), .SIDE_W(1)) u_rot_lon (
      .clock, .reset, .advance,
      .in_valid(v0_ff), .in_x(GAIN_Q30), .in_y('0), .in_z(fl_ff.z), .in_side(fl_ff.neg),
      .out_valid(rl_v), .out_x(rl_x), .out_y(rl_y), .out_z(rl_z), .out_side(rl_n));

   ecl2eq_cordic #(.ANGLE_BITS(AW), .ITERATIONS(CORDIC_ITERATIONS),
                   .VECTORING(1'b0), .SIDE_W(1)) u_rot_lat (
      .clock, .reset, .advance,
      .in_valid(v0_ff), .in_x(GAIN_Q30), .in_y('0), .in_z(fb_ff.z), .in_side(fb_ff.neg),
      .out_valid(rb_v), .out_x(rb_x), .out_y(rb_y), .out_z(rb_z), .out_side(rb_n));

   ecl2eq_cordic #(.ANGLE_BITS(AW), .ITERATIONS(CORDIC_ITERATIONS),
                   .VECTORING(1'b0), .SIDE_W(1)) u_rot_obl (
      .clock, .reset, .advance,
      .in_valid(v0_ff), .in_x(GAIN_Q30), .in_y('0), .in_z(fe_ff.z), .in_side(fe_ff.neg),
      .out_valid(re_v), .out_x(re_x), .out_y(re_y), .out_z(re_z), .out_side(re_n));

   // stage 1: undo the half-turn flip
   vec_type cl_ff, sl_ff, cb_ff, sb_ff, ce_ff, se_ff;
   logic    v1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= rl_v;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         cl_ff <= rl_n ? -rl_x : rl_x;
         sl_ff <= rl_n ? -rl_y : rl_y;
         cb_ff <= rb_n ? -rb_x : rb_x;
         sb_ff <= rb_n ? -rb_y : rb_y;
         ce_ff <= re_n ? -re_x : re_x;
         se_ff <= re_n ? -re_y : re_y;
      end
   end

   // stage 2: first products
   vec_type x2_ff, p1_ff, p2_ff, p3_ff, p4_ff, ce2_ff, sl2_ff;
   logic    v2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         x2_ff  <= mulq(cb_ff, cl_ff);
         p1_ff  <= mulq(cb_ff, sl_ff);
         p2_ff  <= mulq(sb_ff, se_ff);
         p3_ff  <= mulq(sb_ff, ce_ff);
         p4_ff  <= mulq(cb_ff, se_ff);
         ce2_ff <= ce_ff;
         sl2_ff <= sl_ff;
      end
   end

   // stage 3: second products
   vec_type x3_ff, q1_ff, q2_ff, p2b_ff, p3b_ff;
   logic    v3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         x3_ff  <= x2_ff;
         q1_ff  <= mulq(p1_ff, ce2_ff);
         q2_ff  <= mulq(p4_ff, sl2_ff);
         p2b_ff <= p2_ff;
         p3b_ff <= p3_ff;
      end
   end

   // stage 4: rotated vector
   vec_type x4_ff, y4_ff, z4_ff;
   logic    v4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         x4_ff <= x3_ff;
         y4_ff <= q1_ff - p2b_ff;
         z4_ff <= p3b_ff + q2_ff;
      end
   end

   // stage 5: right-ascension arctangent setup (left half-plane flip)
   vec_type  x5_ff, y5_ff, zc5_ff;
   zang_type a5_ff;
   logic     zero5_ff;
   logic     v5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         zero5_ff <= (x4_ff == 0) && (y4_ff == 0);
         zc5_ff   <= z4_ff;
         if (x4_ff < 0) begin
            x5_ff <= -x4_ff;
            y5_ff <= -y4_ff;
            a5_ff <= HALF_Z;
         end else begin
            x5_ff <= x4_ff;
            y5_ff <= y4_ff;
            a5_ff <= '0;
         end
      end
   end

   logic     va_v;
   vec_type  va_x, va_y;
   zang_type va_z;
   logic [VEC_W:0] va_side;

   ecl2eq_cordic #(.ANGLE_BITS(AW), .ITERATIONS(CORDIC_ITERATIONS),
                   .VECTORING(1'b1), .SIDE_W(VEC_W + 1)) u_vec_ra (
      .clock, .reset, .advance,
      .in_valid(v5_ff), .in_x(x5_ff), .in_y(y5_ff), .in_z(a5_ff),
      .in_side({zero5_ff, zc5_ff}),
      .out_valid(va_v), .out_x(va_x), .out_y(va_y), .out_z(va_z), .out_side(va_side));

   // stage 6: right ascension and gain-corrected hypotenuse
   logic [AW-1:0] ra6_ff;
   vec_type       h6_ff, z6_ff;
   logic          v6_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= va_v;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         z6_ff <= va_side[VEC_W-1:0];
         if (va_side[VEC_W]) begin
            ra6_ff <= '0;
            h6_ff  <= '0;
         end else begin
            ra6_ff <= va_z[AW-1:0];
            h6_ff  <= mulq(va_x, GAIN_Q30);
         end
      end
   end

   // stage 7: declination arctangent setup
   vec_type       x7_ff, y7_ff;
   zang_type      a7_ff;
   logic [AW-1:0] ra7_ff;
   logic          zero7_ff;
   logic          v7_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (advance) begin
         v7_ff <= v6_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         zero7_ff <= (h6_ff == 0) && (z6_ff == 0);
         ra7_ff   <= ra6_ff;
         if (h6_ff < 0) begin
            x7_ff <= -h6_ff;
            y7_ff <= -z6_ff;
            a7_ff <= HALF_Z;
         end else begin
            x7_ff <= h6_ff;
            y7_ff <= z6_ff;
            a7_ff <= '0;
         end
      end
   end

   logic          vd_v;
   vec_type       vd_x, vd_y;
   zang_type      vd_z;
   logic [AW:0]   vd_side;

   ecl2eq_cordic #(.ANGLE_BITS(AW), .ITERATIONS(CORDIC_ITERATIONS),
                   .VECTORING(1'b1), .SIDE_W(AW + 1)) u_vec_dec (
      .clock, .reset, .advance,
      .in_valid(v7_ff), .in_x(x7_ff), .in_y(y7_ff), .in_z(a7_ff),
      .in_side({zero7_ff, ra7_ff}),
      .out_valid(vd_v), .out_x(vd_x), .out_y(vd_y), .out_z(vd_z), .out_side(vd_side));

   // output stage: clamp declination, scale both angles to 32 bits
   zang_type dec_z;
   rsp_type  rsp_in;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;

   always_comb begin
      if (vd_side[AW]) begin
         dec_z = '0;
      end else if (vd_z > QUARTER_Z) begin
         dec_z = QUARTER_Z;
      end else if (vd_z < -QUARTER_Z) begin
         dec_z = -QUARTER_Z;
      end else begin
         dec_z = vd_z;
      end
      rsp_in.right_ascension = angle_out(vd_side[AW-1:0]);
      rsp_in.declination     = angle_out(dec_z[AW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vd_v;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // unused CORDIC residuals
   logic unused_ok;
   assign unused_ok = ^{rl_z, rb_z, re_z, va_y, vd_x, vd_y};

   // an accepted transfer lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v0_ff)
      else $error("accepted transfer lost at pipeline entry");

   // a held result freezes the pipeline
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(v0_ff) && $stable(v5_ff) && $stable(v7_ff)))
      else $error("pipeline moved while result held");

   // nothing leaves right after reset
   a_reset_clean: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid directly after reset");

   // declination stays within a quarter turn
   a_dec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.declination <= 32'sd1073741824 &&
                     rsp_payload.declination >= -32'sd1073741824))
      else $error("declination out of range");

endmodule
